// File: rtl/core/iee_pkg.sv
// ============================================================================
// iee_pkg
// Shared types and codes for the infix expression evaluator.
// ============================================================================
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] OP_LPAR = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_ADD   = 8'd43;
    localparam logic [7:0] CH_SUB   = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic                   start;
        logic [2:0]             op;
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] result;
    } alu_rsp_t;

endpackage

// File: rtl/core/infix_expression_evaluator.sv
// ============================================================================
// infix_expression_evaluator
// Two-stack infix evaluator with an iterative shared arithmetic unit.
// ============================================================================
// Usage:
//   Feed the expression one ASCII character per item on s_character, with
//   s_last_char high on the final one. An operator or closing parenthesis
//   reduces stacked operators through the arithmetic unit, and a divide
//   takes longer than an add, subtract or multiply. The stacks sit in
//   simple dual-port RAMs with registered reads, so each pop waits for
//   read data, and the divider yields one quotient bit per cycle.
//   s_ready is low while an item is processed. Only the final character
//   produces a result item (m_value, m_status); m_value is 0 whenever
//   m_status is not ok. After the final character, all remaining
//   operators are reduced before m_valid rises. The result is held until
//   taken; while the receiver stalls, no further item is accepted.
//   After the result is taken all state returns to reset: counts,
//   accumulator and error status clear. Reset (aresetn low, synchronous)
//   clears the same state; stack contents need no clearing.
// ============================================================================
module infix_expression_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status
);

    localparam int W  = iee_pkg::VALUE_WIDTH;
    localparam int PW = iee_pkg::PTR_W;
    localparam int CW = iee_pkg::CNT_W;
    localparam logic [CW-1:0] FULL = CW'(iee_pkg::STACK_DEPTH);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_RED    = 4'd2;  // decide next reduction step
    localparam logic [3:0] S_RDOP   = 4'd3;  // operator top read data valid
    localparam logic [3:0] S_RDB    = 4'd4;
    localparam logic [3:0] S_RDA    = 4'd5;
    localparam logic [3:0] S_ALU    = 4'd6;
    localparam logic [3:0] S_WAIT   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_RES    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_RDB2   = 4'd11;

    // Reduction modes
    localparam logic [1:0] M_OPER = 2'd0;
    localparam logic [1:0] M_RPAR = 2'd1;
    localparam logic [1:0] M_END  = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;   // operand count
    logic [CW-1:0] pcnt_reg, pcnt_next;   // operator count
    logic [W-1:0]  acc_reg, acc_next;
    logic          pend_reg, pend_next;
    logic [1:0]    err_reg, err_next;
    logic [7:0]    ch_reg, ch_next;
    logic          last_reg, last_next;
    logic [2:0]    code_reg, code_next;
    logic [2:0]    top_reg, top_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  val_reg, val_next;
    logic [1:0]    sts_reg, sts_next;

    logic          dwe, pwe;
    logic [PW-1:0] dwaddr, draddr, pwaddr, praddr;
    logic [W-1:0]  dwdata, drdata;
    logic [2:0]    pwdata, prdata;

    iee_pkg::alu_req_t req;
    iee_pkg::alu_rsp_t rsp;

    logic          is_digit;
    logic [2:0]    ch_code;
    logic          ch_op;
    logic [W-1:0]  acc_mul;

    iee_ram #(.WIDTH(W), .DEPTH(iee_pkg::STACK_DEPTH)) u_operand_ram (
        .aclk, .we(dwe), .waddr(dwaddr), .wdata(dwdata), .raddr(draddr), .rdata(drdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(iee_pkg::STACK_DEPTH)) u_operator_ram (
        .aclk, .we(pwe), .waddr(pwaddr), .wdata(pwdata), .raddr(praddr), .rdata(prdata)
    );

    iee_alu u_alu (.aclk, .aresetn, .req, .rsp);

    assign is_digit = (ch_reg >= iee_pkg::CH_ZERO) && (ch_reg <= iee_pkg::CH_NINE);
    assign acc_mul  = (acc_reg << 3) + (acc_reg << 1);

    // Decode operator characters
    always_comb begin
        ch_op   = 1'b1;
        ch_code = iee_pkg::OP_LPAR;
        unique case (ch_reg)
            iee_pkg::CH_ADD: ch_code = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: ch_code = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: ch_code = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: ch_code = iee_pkg::OP_DIV;
            default:         ch_op   = 1'b0;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ocnt_next  = ocnt_reg;
        pcnt_next  = pcnt_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        code_next  = code_reg;
        top_next   = top_reg;
        b_next     = b_reg;
        val_next   = val_reg;
        sts_next   = sts_reg;
        dwe        = 1'b0;
        dwaddr     = ocnt_reg[PW-1:0];
        dwdata     = acc_reg;
        draddr     = ocnt_reg[PW-1:0] - PW'(1);
        pwe        = 1'b0;
        pwaddr     = pcnt_reg[PW-1:0];
        pwdata     = ch_code;
        praddr     = pcnt_reg[PW-1:0] - PW'(1);
        req.start  = 1'b0;
        req.op     = top_reg;
        req.a      = drdata;
        req.b      = b_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ch_next    = s_character;
                    last_next  = s_last_char;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (err_reg != iee_pkg::ST_OK) begin
                    state_next = last_reg ? S_RES : S_IDLE;
                end else if (is_digit) begin
                    acc_next   = acc_mul + W'(ch_reg - iee_pkg::CH_ZERO);
                    pend_next  = 1'b1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end else begin
                    // flush a pending number first
                    if (pend_reg) begin
                        if (ocnt_reg == FULL) begin
                            err_next = iee_pkg::ST_OVERFLOW;
                        end else begin
                            dwe       = 1'b1;
                            ocnt_next = ocnt_reg + CW'(1);
                        end
                        acc_next  = '0;
                        pend_next = 1'b0;
                    end
                    if (pend_reg && ocnt_reg == FULL) begin
                        state_next = last_reg ? S_RES : S_IDLE;
                    end else if (ch_reg == iee_pkg::CH_LPAR) begin
                        if (pcnt_reg == FULL) begin
                            err_next = iee_pkg::ST_OVERFLOW;
                        end else begin
                            pwe       = 1'b1;
                            pwdata    = iee_pkg::OP_LPAR;
                            pcnt_next = pcnt_reg + CW'(1);
                        end
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end else if (ch_reg == iee_pkg::CH_RPAR) begin
                        mode_next  = M_RPAR;
                        state_next = S_RED;
                    end else if (ch_op) begin
                        code_next  = ch_code;
                        mode_next  = M_OPER;
                        state_next = S_RED;
                    end else begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_RES : S_IDLE;
                    end
                end
            end
            S_RED: begin
                // read operator top (address settles this cycle)
                if (err_reg != iee_pkg::ST_OK) begin
                    state_next = last_reg ? S_RES : S_IDLE;
                end else if (pcnt_reg == '0) begin
                    unique case (mode_reg)
                        M_RPAR: begin
                            err_next   = iee_pkg::ST_MALFORMED;
                            state_next = last_reg ? S_RES : S_IDLE;
                        end
                        M_OPER: begin
                            pwe        = 1'b1;
                            pwdata     = code_reg;
                            pcnt_next  = pcnt_reg + CW'(1);
                            state_next = last_reg ? S_FIN : S_IDLE;
                        end
                        default: begin
                            if (ocnt_reg != CW'(1)) begin
                                err_next = iee_pkg::ST_MALFORMED;
                            end
                            state_next = S_RES;
                        end
                    endcase
                end else begin
                    state_next = S_RDOP;
                end
            end
            S_RDOP: begin
                top_next = prdata;
                if (prdata == iee_pkg::OP_LPAR) begin
                    unique case (mode_reg)
                        M_RPAR: begin
                            pcnt_next  = pcnt_reg - CW'(1);
                            state_next = last_reg ? S_FIN : S_IDLE;
                        end
                        M_OPER: begin
                            if (pcnt_reg == FULL) begin
                                err_next = iee_pkg::ST_OVERFLOW;
                            end else begin
                                pwe       = 1'b1;
                                pwdata    = code_reg;
                                pcnt_next = pcnt_reg + CW'(1);
                            end
                            state_next = last_reg ? S_FIN : S_IDLE;
                        end
                        default: begin
                            err_next   = iee_pkg::ST_MALFORMED;
                            state_next = S_RES;
                        end
                    endcase
                end else if (mode_reg == M_OPER
                             && (code_reg == iee_pkg::OP_MUL || code_reg == iee_pkg::OP_DIV)
                             && !(prdata == iee_pkg::OP_MUL || prdata == iee_pkg::OP_DIV)) begin
                    if (pcnt_reg == FULL) begin
                        err_next = iee_pkg::ST_OVERFLOW;
                    end else begin
                        pwe       = 1'b1;
                        pwdata    = code_reg;
                        pcnt_next = pcnt_reg + CW'(1);
                    end
                    state_next = last_reg ? S_FIN : S_IDLE;
                end else begin
                    // pop operator and apply it
                    pcnt_next = pcnt_reg - CW'(1);
                    if (ocnt_reg < CW'(2)) begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_RES : S_IDLE;
                    end else begin
                        state_next = S_RDB;
                    end
                end
            end
            S_RDB: begin
                // address for b is issued; wait for data
                state_next = S_RDB2;
            end
            S_RDB2: begin
                b_next     = drdata;
                draddr     = ocnt_reg[PW-1:0] - PW'(2);
                state_next = S_RDA;
            end
            S_RDA: begin
                draddr = ocnt_reg[PW-1:0] - PW'(2);
                if (top_reg == iee_pkg::OP_DIV && b_reg == '0) begin
                    err_next   = iee_pkg::ST_DIVZERO;
                    state_next = last_reg && mode_reg != M_END ? S_RES
                               : (mode_reg == M_END ? S_RES : S_IDLE);
                end else begin
                    req.start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (rsp.done) begin
                    // pop two, push the result at the lower slot
                    dwe        = 1'b1;
                    dwaddr     = ocnt_reg[PW-1:0] - PW'(2);
                    dwdata     = rsp.result;
                    ocnt_next  = ocnt_reg - CW'(1);
                    state_next = S_RED;
                end
            end
            S_FIN: begin
                // end of expression: flush the number, then reduce all
                mode_next = M_END;
                if (pend_reg) begin
                    pend_next = 1'b0;
                    acc_next  = '0;
                    if (ocnt_reg == FULL) begin
                        err_next   = iee_pkg::ST_OVERFLOW;
                        state_next = S_RES;
                    end else begin
                        dwe        = 1'b1;
                        ocnt_next  = ocnt_reg + CW'(1);
                        state_next = S_RED;
                    end
                end else begin
                    state_next = S_RED;
                end
                draddr = '0;
            end
            S_RES: begin
                // address operand 0 so its value is ready in S_OUT
                draddr     = '0;
                state_next = S_OUT;
                sts_next   = err_reg;
                val_next   = '0;
            end
            S_OUT: begin
                draddr = '0;
                if (sts_reg == iee_pkg::ST_OK && val_reg == '0) begin
                    val_next = drdata;
                end
                if (m_ready) begin
                    state_next = S_IDLE;
                    ocnt_next  = '0;
                    pcnt_next  = '0;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    err_next   = iee_pkg::ST_OK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ocnt_reg  <= '0;
            pcnt_reg  <= '0;
            acc_reg   <= '0;
            pend_reg  <= 1'b0;
            err_reg   <= iee_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            ocnt_reg  <= ocnt_next;
            pcnt_reg  <= pcnt_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
        end
        mode_reg <= mode_next;
        ch_reg   <= ch_next;
        last_reg <= last_next;
        code_reg <= code_next;
        top_reg  <= top_next;
        b_reg    <= b_next;
        val_reg  <= val_next;
        sts_reg  <= sts_next;
    end

    // Show the result straight from the operand RAM read register in S_OUT
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_OUT);
    assign m_status = sts_reg;
    assign m_value  = (sts_reg == iee_pkg::ST_OK) ? drdata : '0;

endmodule

// File: rtl/core/iee_ram.sv
// ============================================================================
// iee_ram
// Generic simple dual-port RAM (one write, one read port) with registered read.
// ============================================================================
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/iee_alu.sv
// ============================================================================
// iee_alu
// Shared arithmetic unit: add, subtract, multiply into a registered result,
// signed division one quotient bit a cycle.
// ============================================================================
module iee_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  iee_pkg::alu_req_t req,
    output iee_pkg::alu_rsp_t rsp
);

    localparam int W = iee_pkg::VALUE_WIDTH;

    logic                            busy_reg, busy_next;
    logic [iee_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                    quo_reg, quo_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    dvs_reg, dvs_next;
    logic                            neg_reg, neg_next;
    logic                            done_reg, done_next;
    logic [W-1:0]                    res_reg, res_next;
    logic [W:0]                      trial;
    logic [W-1:0]                    rem_sh;
    logic [W-1:0]                    ua, ub;

    assign ua = req.a[W-1] ? (~req.a + W'(1)) : req.a;
    assign ub = req.b[W-1] ? (~req.b + W'(1)) : req.b;
    assign rem_sh = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    // Sequence one operation
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (busy_reg) begin
            rem_next = trial[W] ? rem_sh : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], ~trial[W]};
            cnt_next = cnt_reg - iee_pkg::DIV_CNT_W'(1);
            if (cnt_reg == iee_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (~quo_next + W'(1)) : quo_next;
            end
        end else if (req.start) begin
            unique case (req.op)
                iee_pkg::OP_ADD: begin
                    res_next  = req.a + req.b;
                    done_next = 1'b1;
                end
                iee_pkg::OP_SUB: begin
                    res_next  = req.a - req.b;
                    done_next = 1'b1;
                end
                iee_pkg::OP_MUL: begin
                    res_next  = W'(req.a * req.b);
                    done_next = 1'b1;
                end
                iee_pkg::OP_DIV: begin
                    busy_next = 1'b1;
                    cnt_next  = iee_pkg::DIV_CNT_W'(W);
                    quo_next  = ua;
                    rem_next  = '0;
                    dvs_next  = ub;
                    neg_next  = req.a[W-1] ^ req.b[W-1];
                end
                default: begin
                    res_next  = '0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// File: bench/infix_expression_evaluator_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// infix_expression_evaluator_checker
// Watches both channels, evaluates each accepted expression with its own
// two-stack model and compares every result item field by field.
// ============================================================================
module infix_expression_evaluator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last_char,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_value,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } eval_result_t;

    logic [31:0] num_stack [iee_pkg::STACK_DEPTH];
    logic [2:0]  op_stack [iee_pkg::STACK_DEPTH];
    int          num_depth;
    int          op_depth;
    logic [31:0] accum;
    logic        accum_live;
    logic [1:0]  err;
    eval_result_t result_queue[$];

    function automatic void flag(logic [1:0] code);
        if (err == iee_pkg::ST_OK) err = code;
    endfunction

    function automatic void push_num(logic [31:0] v);
        if (num_depth >= iee_pkg::STACK_DEPTH) begin
            flag(iee_pkg::ST_OVERFLOW);
        end else begin
            num_stack[num_depth] = v;
            num_depth++;
        end
    endfunction

    function automatic void push_op(logic [2:0] op);
        if (op_depth >= iee_pkg::STACK_DEPTH) begin
            flag(iee_pkg::ST_OVERFLOW);
        end else begin
            op_stack[op_depth] = op;
            op_depth++;
        end
    endfunction

    // Pop one operator and fold the two top operands
    function automatic void reduce_top();
        logic [2:0]         op;
        logic signed [31:0] a, b;
        logic [31:0]        r;
        if (op_depth == 0) return;
        op_depth--;
        op = op_stack[op_depth];
        if (num_depth < 2) begin
            flag(iee_pkg::ST_MALFORMED);
            return;
        end
        b = num_stack[num_depth - 1];
        a = num_stack[num_depth - 2];
        num_depth -= 2;
        r = '0;
        case (op)
            iee_pkg::OP_ADD: r = a + b;
            iee_pkg::OP_SUB: r = a - b;
            iee_pkg::OP_MUL: r = a * b;
            iee_pkg::OP_DIV: begin
                if (b == 0) flag(iee_pkg::ST_DIVZERO);
                else if (a == 32'sh8000_0000 && b == -1) r = a;
                else r = a / b;
            end
            default: flag(iee_pkg::ST_MALFORMED);
        endcase
        push_num(r);
    endfunction

    function automatic void clear_eval();
        num_depth  = 0;
        op_depth   = 0;
        accum      = '0;
        accum_live = 1'b0;
        err        = iee_pkg::ST_OK;
    endfunction

    function automatic void take_char(logic [7:0] ch);
        logic [2:0] op;
        logic [2:0] top;
        if (ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE) begin
            accum      = 32'(accum * 10 + 32'(ch - iee_pkg::CH_ZERO));
            accum_live = 1'b1;
            return;
        end
        if (accum_live) begin
            push_num(accum);
            accum      = '0;
            accum_live = 1'b0;
        end
        case (ch)
            iee_pkg::CH_LPAR: begin
                push_op(iee_pkg::OP_LPAR);
                return;
            end
            iee_pkg::CH_RPAR: begin
                while (err == iee_pkg::ST_OK && op_depth > 0
                       && op_stack[op_depth - 1] != iee_pkg::OP_LPAR)
                    reduce_top();
                if (err != iee_pkg::ST_OK) return;
                if (op_depth == 0) flag(iee_pkg::ST_MALFORMED);
                else op_depth--;
                return;
            end
            iee_pkg::CH_ADD: op = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: op = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: op = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: op = iee_pkg::OP_DIV;
            default: begin
                flag(iee_pkg::ST_MALFORMED);
                return;
            end
        endcase
        while (err == iee_pkg::ST_OK && op_depth > 0) begin
            top = op_stack[op_depth - 1];
            if (top == iee_pkg::OP_LPAR) break;
            if ((op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV)
                && !(top == iee_pkg::OP_MUL || top == iee_pkg::OP_DIV)) break;
            reduce_top();
        end
        if (err == iee_pkg::ST_OK) push_op(op);
    endfunction

    // Finish the expression and queue its result
    function automatic void close_expr();
        eval_result_t res;
        if (err == iee_pkg::ST_OK && accum_live) push_num(accum);
        while (err == iee_pkg::ST_OK && op_depth > 0) begin
            if (op_stack[op_depth - 1] == iee_pkg::OP_LPAR) begin
                flag(iee_pkg::ST_MALFORMED);
                break;
            end
            reduce_top();
        end
        if (err == iee_pkg::ST_OK && num_depth != 1) flag(iee_pkg::ST_MALFORMED);
        res.status = err;
        res.value  = (err == iee_pkg::ST_OK) ? num_stack[0] : '0;
        result_queue.push_back(res);
        clear_eval();
    endfunction

    always @(posedge aclk) begin
        eval_result_t want;
        if (!aresetn) begin
            clear_eval();
            result_queue.delete();
            fail_count <= 0;
        end else begin
            // Predict on every accepted item
            if (s_valid && s_ready) begin
                if (err == iee_pkg::ST_OK) take_char(s_character);
                if (s_last_char) close_expr();
            end
            // Compare every accepted result item
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: value=%0d status=%0d",
                                 $signed(m_value), m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (want.value !== m_value || want.status !== m_status) begin
                        if (fail_count < 10)
                            $display("mismatch: exp value=%0d status=%0d got value=%0d status=%0d",
                                     $signed(want.value), want.status,
                                     $signed(m_value), m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_results = result_queue.size();
    end

endmodule

// File: bench/infix_expression_evaluator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// infix_expression_evaluator_tb
// Feeds directed and random expressions with random gaps and stalls, and
// leaves the checking to the checker module.
// ============================================================================
module infix_expression_evaluator_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_AFTER  = 30;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_character;
    logic        s_last_char;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending_results;
    int          cycle_count = 0;

    infix_expression_evaluator DUT (.*);

    infix_expression_evaluator_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[infix_expression_evaluator] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int w;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (taken == HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
            taken++;
        end
    end

    logic [7:0] expr_chars[$];
    int         gap_max;

    task automatic send_item(logic [7:0] ch, logic last);
        int w;
        w = $urandom_range(0, gap_max);
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        s_last_char <= last;
        @(posedge aclk iff s_ready);
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return iee_pkg::CH_ADD;
            1: return iee_pkg::CH_SUB;
            2: return iee_pkg::CH_MUL;
            default: return iee_pkg::CH_DIV;
        endcase
    endfunction

    // Build a mostly well-formed expression, nesting kept shallow
    function automatic void build_expr(int lvl);
        int terms;
        int digits;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) expr_chars.push_back(rand_op());
            if (lvl < 3 && $urandom_range(0, 4) == 0) begin
                expr_chars.push_back(iee_pkg::CH_LPAR);
                build_expr(lvl + 1);
                expr_chars.push_back(iee_pkg::CH_RPAR);
            end else begin
                digits = $urandom_range(0, 5) == 0 ? $urandom_range(5, 11) : $urandom_range(1, 2);
                for (int d = 0; d < digits; d++)
                    expr_chars.push_back(8'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
        end
    endfunction

    initial begin
        int sent;
        int n;
        gap_max     = 8;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_character = '0;
        s_last_char = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed expressions
        send_text("1+2*3");
        send_text("(1+2)*3-4/2");
        send_text("4294967295*2");
        send_text("2147483648/0-1");
        send_text("0-2147483648/(0-1)");
        send_text("0-7/2");
        send_text("7/0");
        send_text("1+");
        send_text("(1");
        send_text("1)");
        send_text("1 2");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(iee_pkg::CH_NINE, 1'b1);

        // Stack overflow: 33 open parentheses
        for (int i = 0; i < 33; i++) send_item(iee_pkg::CH_LPAR, 1'b0);
        send_text("5");

        // Wait for every expected result to drain
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        @(posedge aclk);

        // Back-to-back items; the receiver's long hold-off lands in here
        gap_max  = 0;
        sent     = 0;
        while (sent < 1950) begin
            if (sent > 300) gap_max = ($urandom_range(0, 5) == 0) ? 0 : 8;
            expr_chars.delete();
            n = $urandom_range(0, 9);
            if (n == 0) begin
                // Noise: arbitrary bytes
                repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_expr(0);
                if (n == 1) begin
                    // Break it: drop or insert a character
                    if (expr_chars.size() > 1 && $urandom_range(0, 1))
                        expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
                    else
                        expr_chars.insert($urandom_range(0, expr_chars.size()),
                                          ($urandom_range(0, 1)) ? iee_pkg::CH_RPAR
                                                                 : rand_op());
                end
            end
            foreach (expr_chars[i])
                send_item(expr_chars[i], i == expr_chars.size() - 1);
            sent += expr_chars.size();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending_results == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("[infix_expression_evaluator] OK");
        else
            $display("[infix_expression_evaluator] ERROR");
        $finish;
    end

endmodule
